// ===== sv/mips_itype_execute_unit_defines.svh =====
// Assertion macros shared by the checker file of the execute unit.
`ifndef MIPS_ITYPE_EXECUTE_UNIT_DEFINES_SVH
`define MIPS_ITYPE_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MIE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MIE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mie_pkg.sv =====
// ----------------------------------------------------------------------------
// mie_pkg
// Types, opcodes and sizes shared by the I-type execute unit.
// ----------------------------------------------------------------------------
package mie_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int MEM_ROWS  = MEM_BYTES / 4;
  localparam int ROW_W     = (MEM_ROWS > 1) ? $clog2(MEM_ROWS) : 1;
  localparam int CLR_N     = (MEM_ROWS > 32) ? MEM_ROWS : 32;
  localparam int CLR_W     = $clog2(CLR_N);

  localparam logic [31:0] MEMORY_BASE_RESET = 32'h0040_0000;
  localparam logic        CFG_IDX_MEMORY_BASE = 1'b0;

  localparam logic [5:0] OP_REGIMM = 6'b000001;
  localparam logic [5:0] OP_BEQ    = 6'b000100;
  localparam logic [5:0] OP_BNE    = 6'b000101;
  localparam logic [5:0] OP_BLEZ   = 6'b000110;
  localparam logic [5:0] OP_BGTZ   = 6'b000111;
  localparam logic [5:0] OP_ADDI   = 6'b001000;
  localparam logic [5:0] OP_ADDIU  = 6'b001001;
  localparam logic [5:0] OP_SLTI   = 6'b001010;
  localparam logic [5:0] OP_SLTIU  = 6'b001011;
  localparam logic [5:0] OP_ANDI   = 6'b001100;
  localparam logic [5:0] OP_ORI    = 6'b001101;
  localparam logic [5:0] OP_XORI   = 6'b001110;
  localparam logic [5:0] OP_LUI    = 6'b001111;
  localparam logic [5:0] OP_LB     = 6'b100000;
  localparam logic [5:0] OP_LH     = 6'b100001;
  localparam logic [5:0] OP_LWL    = 6'b100010;
  localparam logic [5:0] OP_LW     = 6'b100011;
  localparam logic [5:0] OP_LBU    = 6'b100100;
  localparam logic [5:0] OP_LHU    = 6'b100101;
  localparam logic [5:0] OP_LWR    = 6'b100110;
  localparam logic [5:0] OP_SB     = 6'b101000;
  localparam logic [5:0] OP_SH     = 6'b101001;
  localparam logic [5:0] OP_SWL    = 6'b101010;
  localparam logic [5:0] OP_SW     = 6'b101011;
  localparam logic [5:0] OP_SWR    = 6'b101110;

  localparam logic [4:0] RT_BLTZ = 5'b00000;
  localparam logic [4:0] RT_BGEZ = 5'b00001;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD_OP = 2'd1,
    ST_BAD_BR = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef struct packed {
    logic [3:0]            en;
    logic [3:0][ROW_W-1:0] row;
    logic [3:0][1:0]       rp;
    logic [3:0][7:0]       wdata;
  } mem_req_t;

  typedef struct packed {
    logic [31:0] val;
    logic        wr;
    logic        taken;
    logic [31:0] next_pc;
    status_t     status;
    logic        is_load;
    logic        is_store;
    logic        keep_b;
    logic        sext_byte;
    logic        sext_half;
    mem_req_t    mem;
  } exec_res_t;

endpackage

// ===== sv/mips_itype_execute_unit.sv =====
// ----------------------------------------------------------------------------
// mips_itype_execute_unit
// Executes one MIPS I-type instruction per transfer against its own
// register file and byte memory.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_ready    opcode, rs, rt, immediate, pc
//  out_     output     out_valid / out_ready  next pc, branch, write, status
//  cfg_     input      APB, pready always 1   memory_base at address 0
//
// One instruction per cycle while the output is not stalled; a result is registered
// by the register file read, the memory read and the output register in turn.
// After reset a clearing pass steps through every row of the memory and register
// file and zeroes them; in_ready stays low meanwhile.
// A stalled output holds the whole pipeline; hazards are forwarded.
// ----------------------------------------------------------------------------
module mips_itype_execute_unit
  import mie_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  in_opcode,
  input  logic [4:0]  in_source_reg,
  input  logic [4:0]  in_target_reg,
  input  logic [15:0] in_imm_field,
  input  logic [31:0] in_pc_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_next_pc,
  output logic        out_branch_taken,
  output logic        out_reg_write,
  output logic [4:0]  out_dest_index,
  output logic [31:0] out_dest_value,
  output logic [1:0]  out_status,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [31:0] memory_base_r;
  logic        clr_busy_r;
  logic [CLR_W-1:0] clr_cnt_r;
  logic        adv;

  logic        s1_valid_r;
  logic [5:0]  s1_op_r;
  logic [4:0]  s1_rs_r;
  logic [4:0]  s1_rt_r;
  logic [15:0] s1_imm_r;
  logic [31:0] s1_pc_r;
  logic [31:0] rf_a;
  logic [31:0] rf_b;
  logic [31:0] op_a;
  logic [31:0] op_b;
  exec_res_t   s1_res;

  logic        s2_valid_r;
  exec_res_t   s2_res_r;
  logic [4:0]  s2_rt_r;
  logic [31:0] s2_b_r;
  logic [3:0][7:0] mem_rd;
  logic [31:0] s2_merged;
  logic [31:0] s2_val;
  logic        s2_wr;
  logic [3:0]  mem_we;

  logic        out_valid_r;
  logic [31:0] out_next_pc_r;
  logic        out_taken_r;
  logic        out_wr_r;
  logic [4:0]  out_idx_r;
  logic [31:0] out_val_r;
  logic [1:0]  out_status_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_MEMORY_BASE) ? memory_base_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      memory_base_r <= MEMORY_BASE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[2] == CFG_IDX_MEMORY_BASE)) begin
      memory_base_r <= cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == CLR_W'(CLR_N - 1)) clr_busy_r <= 1'b0;
    end
  end

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && !clr_busy_r;

  mie_regfile u_regfile (
    .clk       (clk),
    .clr_en    (clr_busy_r),
    .clr_addr  (clr_cnt_r[4:0]),
    .rd_en     (adv),
    .rd_addr_a (in_source_reg),
    .rd_addr_b (in_target_reg),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b),
    .wr_en     (s2_valid_r && s2_wr && adv),
    .wr_addr   (s2_rt_r),
    .wr_data   (s2_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r  <= in_opcode;
      s1_rs_r  <= in_source_reg;
      s1_rt_r  <= in_target_reg;
      s1_imm_r <= in_imm_field;
      s1_pc_r  <= in_pc_value;
    end
  end

  assign op_a = (s2_valid_r && s2_wr && (s2_rt_r == s1_rs_r)) ? s2_val : rf_a;
  assign op_b = (s2_valid_r && s2_wr && (s2_rt_r == s1_rt_r)) ? s2_val : rf_b;

  mie_exec u_exec (
    .opcode      (s1_op_r),
    .target_reg  (s1_rt_r),
    .imm_field   (s1_imm_r),
    .pc_value    (s1_pc_r),
    .op_a        (op_a),
    .op_b        (op_b),
    .memory_base (memory_base_r),
    .res         (s1_res)
  );

  assign mem_we = s2_res_r.mem.en & {4{s2_valid_r && s2_res_r.is_store && adv}};

  mie_datamem u_datamem (
    .clk     (clk),
    .clr_en  (clr_busy_r),
    .clr_row (clr_cnt_r[ROW_W-1:0]),
    .rd_en   (adv),
    .rd_req  (s1_res.mem),
    .wr_en   (mem_we),
    .wr_req  (s2_res_r.mem),
    .rd_data (mem_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_res_r <= s1_res;
      s2_rt_r  <= s1_rt_r;
      s2_b_r   <= op_b;
    end
  end

  always_comb begin
    s2_merged = s2_res_r.keep_b ? s2_b_r : 32'd0;
    for (int p = 0; p < 4; p++) begin
      for (int j = 0; j < 4; j++) begin
        if (s2_res_r.mem.en[j] && (s2_res_r.mem.rp[j] == 2'(p))) begin
          s2_merged[8*p +: 8] = mem_rd[j];
        end
      end
    end
    if (s2_res_r.sext_byte) s2_merged = {{24{s2_merged[7]}}, s2_merged[7:0]};
    if (s2_res_r.sext_half) s2_merged = {{16{s2_merged[15]}}, s2_merged[15:0]};
  end

  assign s2_val = s2_res_r.is_load ? s2_merged : s2_res_r.val;
  assign s2_wr  = s2_res_r.wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_next_pc_r <= s2_res_r.next_pc;
      out_taken_r   <= s2_res_r.taken;
      out_wr_r      <= s2_wr;
      out_idx_r     <= s2_wr ? s2_rt_r : 5'd0;
      out_val_r     <= s2_wr ? s2_val : 32'd0;
      out_status_r  <= s2_res_r.status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_pc      = out_next_pc_r;
  assign out_branch_taken = out_taken_r;
  assign out_reg_write    = out_wr_r;
  assign out_dest_index   = out_idx_r;
  assign out_dest_value   = out_val_r;
  assign out_status       = out_status_r;

endmodule

// ===== sv/mie_regfile.sv =====
// ----------------------------------------------------------------------------
// mie_regfile
// 32 x 32 register file, two registered read ports with write bypass.
// ----------------------------------------------------------------------------
module mie_regfile
  import mie_pkg::*;
(
  input  logic        clk,
  input  logic        clr_en,
  input  logic [4:0]  clr_addr,
  input  logic        rd_en,
  input  logic [4:0]  rd_addr_a,
  input  logic [4:0]  rd_addr_b,
  output logic [31:0] rd_data_a,
  output logic [31:0] rd_data_b,
  input  logic        wr_en,
  input  logic [4:0]  wr_addr,
  input  logic [31:0] wr_data
);

  logic [31:0] rf_mem [32];
  logic [31:0] rd_a_r;
  logic [31:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (clr_en) begin
      rf_mem[clr_addr] <= '0;
    end else if (wr_en) begin
      rf_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : rf_mem[rd_addr_a];
      rd_b_r <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : rf_mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ===== sv/mie_datamem.sv =====
// ----------------------------------------------------------------------------
// mie_datamem
// Byte memory in four byte-interleaved banks, registered read with bypass.
// ----------------------------------------------------------------------------
module mie_datamem
  import mie_pkg::*;
(
  input  logic                  clk,
  input  logic                  clr_en,
  input  logic [ROW_W-1:0]      clr_row,
  input  logic                  rd_en,
  input  mem_req_t              rd_req,
  input  logic [3:0]            wr_en,
  input  mem_req_t              wr_req,
  output logic [3:0][7:0]       rd_data
);

  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [7:0] bank_mem [MEM_ROWS];
    logic [7:0] rd_r;

    always_ff @(posedge clk) begin
      if (clr_en) begin
        bank_mem[clr_row] <= '0;
      end else if (wr_en[j]) begin
        bank_mem[wr_req.row[j]] <= wr_req.wdata[j];
      end
      if (rd_en) begin
        rd_r <= (wr_en[j] && (wr_req.row[j] == rd_req.row[j])) ?
                wr_req.wdata[j] : bank_mem[rd_req.row[j]];
      end
    end

    assign rd_data[j] = rd_r;
  end

endmodule

// ===== sv/mie_exec.sv =====
// ----------------------------------------------------------------------------
// mie_exec
// Operand stage logic: ALU, branch test, address and bank lane setup.
// ----------------------------------------------------------------------------
module mie_exec
  import mie_pkg::*;
(
  input  logic [5:0]  opcode,
  input  logic [4:0]  target_reg,
  input  logic [15:0] imm_field,
  input  logic [31:0] pc_value,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  input  logic [31:0] memory_base,
  output exec_res_t   res
);

  logic [31:0] simm;
  logic [31:0] uimm;
  logic [31:0] ea;
  logic [1:0]  k;
  logic [31:0] start;
  logic [2:0]  len;
  logic [1:0]  shift;
  logic        is_mem;
  logic        range_ok;
  logic        cond;
  logic        is_br;
  logic [1:0]  s_lo;
  logic [ROW_W-1:0] s_row;
  logic [1:0]  idx [4];
  exec_res_t   r;

  assign simm = {{16{imm_field[15]}}, imm_field};
  assign uimm = {16'h0000, imm_field};
  assign ea   = op_a + simm;
  assign k    = ea[1:0];

  always_comb begin
    r = '0;
    r.status  = ST_OK;
    r.next_pc = pc_value;
    cond   = 1'b0;
    is_br  = 1'b0;
    is_mem = 1'b0;
    len    = 3'd0;
    shift  = 2'd0;
    start  = ea - memory_base;
    unique case (opcode)
      OP_ADDI, OP_ADDIU: begin r.val = ea;          r.wr = 1'b1; end
      OP_ANDI:  begin r.val = op_a & uimm;          r.wr = 1'b1; end
      OP_ORI:   begin r.val = op_a | uimm;          r.wr = 1'b1; end
      OP_XORI:  begin r.val = op_a ^ uimm;          r.wr = 1'b1; end
      OP_SLTI:  begin
        r.val = {31'd0, $signed(op_a) < $signed(simm)}; r.wr = 1'b1;
      end
      OP_SLTIU: begin r.val = {31'd0, op_a < simm}; r.wr = 1'b1; end
      OP_LUI:   begin r.val = {imm_field, 16'h0000}; r.wr = 1'b1; end
      OP_BEQ:   begin is_br = 1'b1; cond = (op_a == op_b); end
      OP_BNE:   begin is_br = 1'b1; cond = (op_a != op_b); end
      OP_REGIMM: begin
        is_br = 1'b1;
        if (target_reg == RT_BGEZ) begin
          cond = !op_a[31];
        end else if (target_reg == RT_BLTZ) begin
          cond = op_a[31];
        end else begin
          r.status = ST_BAD_BR;
        end
      end
      OP_BGTZ: begin
        is_br = 1'b1;
        if (target_reg == 5'd0) cond = !op_a[31] && (op_a != 32'd0);
        else r.status = ST_BAD_BR;
      end
      OP_BLEZ: begin
        is_br = 1'b1;
        if (target_reg == 5'd0) cond = op_a[31] || (op_a == 32'd0);
        else r.status = ST_BAD_BR;
      end
      OP_LB, OP_LBU: begin
        is_mem = 1'b1; r.is_load = 1'b1; r.wr = 1'b1; len = 3'd1;
        r.sext_byte = (opcode == OP_LB);
      end
      OP_LH, OP_LHU: begin
        is_mem = 1'b1; r.is_load = 1'b1; r.wr = 1'b1; len = 3'd2;
        r.sext_half = (opcode == OP_LH);
      end
      OP_LW: begin is_mem = 1'b1; r.is_load = 1'b1; r.wr = 1'b1; len = 3'd4; end
      OP_SB: begin is_mem = 1'b1; r.is_store = 1'b1; len = 3'd1; end
      OP_SH: begin is_mem = 1'b1; r.is_store = 1'b1; len = 3'd2; end
      OP_SW: begin is_mem = 1'b1; r.is_store = 1'b1; len = 3'd4; end
      OP_LWL: begin
        is_mem = 1'b1; r.is_load = 1'b1; r.wr = 1'b1; r.keep_b = 1'b1;
        len = 3'd4 - {1'b0, k};
      end
      OP_SWL: begin is_mem = 1'b1; r.is_store = 1'b1; len = 3'd4 - {1'b0, k}; end
      OP_LWR: begin
        is_mem = 1'b1; r.is_load = 1'b1; r.wr = 1'b1; r.keep_b = 1'b1;
        len = {1'b0, k}; shift = 2'd0 - k; start = ea - {30'd0, k} - memory_base;
      end
      OP_SWR: begin
        is_mem = 1'b1; r.is_store = 1'b1;
        len = {1'b0, k}; shift = 2'd0 - k; start = ea - {30'd0, k} - memory_base;
      end
      default: r.status = ST_BAD_OP;
    endcase

    range_ok = (len == 3'd0) ||
               (({1'b0, start} + {30'd0, len}) <= 33'(MEM_BYTES));
    if (is_mem && !range_ok) r.status = ST_RANGE;

    s_lo  = start[1:0];
    s_row = start[ROW_W+1:2];
    for (int j = 0; j < 4; j++) begin
      idx[j]       = 2'(j) - s_lo;
      r.mem.row[j] = (2'(j) >= s_lo) ? s_row : s_row + 1'b1;
      r.mem.rp[j]  = idx[j] + shift;
      r.mem.en[j]  = is_mem && ({1'b0, idx[j]} < len);
      r.mem.wdata[j] = op_b[8*r.mem.rp[j] +: 8];
    end

    if (r.status != ST_OK) begin
      r.wr = 1'b0; r.val = '0; r.is_load = 1'b0; r.is_store = 1'b0; r.mem.en = '0;
    end
    if (target_reg == 5'd0) r.wr = 1'b0;
    r.taken = is_br && (r.status == ST_OK) && cond;
    if (r.taken) r.next_pc = pc_value + {simm[29:0], 2'b00};
    res = r;
  end

endmodule

// ===== sv/mie_checker.sv =====
// ----------------------------------------------------------------------------
// mie_checker
// Port-level checks on the result channel of the execute unit.
// ----------------------------------------------------------------------------
`include "mips_itype_execute_unit_defines.svh"

module mie_checker
  import mie_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_next_pc,
  input logic        out_branch_taken,
  input logic        out_reg_write,
  input logic [4:0]  out_dest_index,
  input logic [31:0] out_dest_value,
  input logic [1:0]  out_status
);

  `MIE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_next_pc) && $stable(out_dest_value), "stalled result transfer changed")
  `MIE_ASSERT_IMP(a_taken_ok, clk, rst_n, out_valid && out_branch_taken, out_status == ST_OK && !out_reg_write, "taken branch with error or write")
  `MIE_ASSERT_IMP(a_write_ok, clk, rst_n, out_valid && out_reg_write, out_status == ST_OK && out_dest_index != 5'd0, "register write with error or to register zero")
  `MIE_ASSERT_IMP(a_nowrite_zero, clk, rst_n, out_valid && !out_reg_write, out_dest_index == 5'd0 && out_dest_value == 32'd0, "destination not zero without a write")

endmodule

bind mips_itype_execute_unit mie_checker u_mie_checker (.*);
